### hw/rtl/tpq_pkg.sv
// Shared types and constants for the priority transmit queues.
package tpq_pkg;

   localparam int HANDLE_W = 16;
   localparam int RATE_W   = 4;
   localparam int COUNT_W  = 32;
   localparam int PROBE_W  = 8;
   localparam int FAIL_W   = 2;

   localparam logic [1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [1:0] CMD_OUTCOME = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic CSR_MAX_RATE     = 1'b0;
   localparam logic CSR_UP_THRESHOLD = 1'b1;

   localparam logic [RATE_W-1:0]  MAX_RATE_RESET = 4'd11;
   localparam logic [PROBE_W-1:0] PROBE_RESET    = 8'd10;
   localparam logic [FAIL_W-1:0]  FAIL_LIMIT     = 2'd3;
   localparam logic [PROBE_W-1:0] SUCCESS_MAX    = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [RATE_W-1:0]   rate;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic [RATE_W-1:0]  max_rate;
      logic [PROBE_W-1:0] up_threshold;
   } rate_cfg_type;

   typedef struct packed {
      logic fire;
      logic ok;
   } rate_event_type;

endpackage

### hw/rtl/tpq_store.sv
// Queue entry memory: one write port, one registered read port.
module tpq_store #(
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  tpq_pkg::entry_type        wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output tpq_pkg::entry_type        rd_data
);
   import tpq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tpq_rate.sv
// Rate adaptation: success/failure runs, rate index and retry counter.
module tpq_rate (
   input  logic                          clock,
   input  logic                          reset,
   input  tpq_pkg::rate_cfg_type         cfg,
   input  tpq_pkg::rate_event_type       evt,
   output logic [tpq_pkg::RATE_W-1:0]    rate_index,
   output logic [tpq_pkg::COUNT_W-1:0]   retry_total
);
   import tpq_pkg::*;

   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [PROBE_W-1:0] succ_ff, succ_in;
   logic [FAIL_W-1:0]  fail_ff, fail_in;
   logic [COUNT_W-1:0] retry_ff, retry_in;
   logic [PROBE_W-1:0] succ_inc;
   logic [FAIL_W-1:0]  fail_inc;

   assign succ_inc = (succ_ff == SUCCESS_MAX) ? succ_ff : succ_ff + PROBE_W'(1);
   assign fail_inc = (fail_ff == FAIL_LIMIT) ? fail_ff : fail_ff + FAIL_W'(1);

   always_comb begin
      rate_in  = rate_ff;
      succ_in  = succ_ff;
      fail_in  = fail_ff;
      retry_in = retry_ff;
      if (evt.fire) begin
         if (evt.ok) begin
            fail_in = '0;
            if (succ_inc >= cfg.up_threshold && rate_ff < cfg.max_rate) begin
               rate_in = rate_ff + RATE_W'(1);
               succ_in = '0;
            end else begin
               succ_in = succ_inc;
            end
         end else begin
            succ_in = '0;
            if (fail_inc >= FAIL_LIMIT && rate_ff != '0) begin
               rate_in  = rate_ff - RATE_W'(1);
               fail_in  = '0;
               retry_in = (retry_ff == COUNT_MAX) ? retry_ff : retry_ff + COUNT_W'(1);
            end else begin
               fail_in = fail_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= '0;
         succ_ff  <= '0;
         fail_ff  <= '0;
         retry_ff <= '0;
      end else begin
         rate_ff  <= rate_in;
         succ_ff  <= succ_in;
         fail_ff  <= fail_in;
         retry_ff <= retry_in;
      end
   end

   assign rate_index  = rate_ff;
   assign retry_total = retry_ff;

endmodule

### hw/rtl/priority_tx_queues_with_rate_adapt.sv
// Strict-priority transmit queues with rate adaptation: top level.
// rsp_valid rises after the req transfer passes the input register and the result register.
// Throughput: one item per cycle unless rsp_ready stalls; memory reads land in result stage.
// rsp_current_rate / drop / retry totals show state right after the item.
// Reset (synchronous): pointers, fill and drop counters, rate state cleared,
// config back to defaults; the entry memory is not cleared.
module priority_tx_queues_with_rate_adapt #(
   parameter int QUEUE_DEPTH    = 16,
   parameter int CATEGORY_COUNT = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [tpq_pkg::PROBE_W-1:0]       csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_cmd,
   input  logic [1:0]                        req_access_category,
   input  logic [tpq_pkg::HANDLE_W-1:0]      req_frame_handle,
   input  logic                              req_outcome_ok,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [1:0]                        rsp_out_category,
   output logic [tpq_pkg::HANDLE_W-1:0]      rsp_out_handle,
   output logic [tpq_pkg::RATE_W-1:0]        rsp_out_rate,
   output logic [tpq_pkg::RATE_W-1:0]        rsp_current_rate,
   output logic [tpq_pkg::COUNT_W-1:0]       rsp_drop_total,
   output logic [tpq_pkg::COUNT_W-1:0]       rsp_retry_total
);
   import tpq_pkg::*;

   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int CAT_W     = $clog2(CATEGORY_COUNT);
   localparam int MEM_DEPTH = CATEGORY_COUNT * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   // configuration
   rate_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_RATE:     cfg_in.max_rate = csr_wdata[RATE_W-1:0];
            CSR_UP_THRESHOLD: cfg_in.up_threshold = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // input stage
   logic                s1_valid_ff, s1_valid_in;
   logic [1:0]          s1_cmd_ff;
   logic [1:0]          s1_cat_ff;
   logic [HANDLE_W-1:0] s1_handle_ff;
   logic                s1_ok_ff;
   logic                adv;

   // result stage
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [1:0] rsp_cat_ff, rsp_cat_in;
   logic       rsp_hit_ff, rsp_hit_in;

   // queue state
   logic [PTR_W-1:0]   head_ff  [CATEGORY_COUNT];
   logic [PTR_W-1:0]   head_in  [CATEGORY_COUNT];
   logic [PTR_W-1:0]   tail_ff  [CATEGORY_COUNT];
   logic [PTR_W-1:0]   tail_in  [CATEGORY_COUNT];
   logic [FILL_W-1:0]  fill_ff  [CATEGORY_COUNT];
   logic [FILL_W-1:0]  fill_in  [CATEGORY_COUNT];
   logic [COUNT_W-1:0] qdrop_ff [CATEGORY_COUNT];
   logic [COUNT_W-1:0] qdrop_in [CATEGORY_COUNT];
   logic [COUNT_W-1:0] drop_ff, drop_in;

   logic [CAT_W-1:0]  enq_idx;
   logic              enq_cat_ok;
   logic              enq_full;
   logic              is_enq, is_deq, is_out;
   logic [CAT_W-1:0]  pick;
   logic              any_ready;
   logic              mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   entry_type         mem_wr_data, mem_rd_data;

   logic [RATE_W-1:0]  rate_index;
   logic [COUNT_W-1:0] retry_total;
   rate_event_type     rate_evt;

   assign adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!s1_valid_ff || adv);

   assign is_enq = (s1_cmd_ff == CMD_ENQUEUE);
   assign is_deq = (s1_cmd_ff == CMD_DEQUEUE);
   assign is_out = (s1_cmd_ff == CMD_OUTCOME);

   assign enq_idx    = CAT_W'(s1_cat_ff);
   assign enq_cat_ok = 32'(s1_cat_ff) < CATEGORY_COUNT;
   assign enq_full   = (fill_ff[enq_idx] == FILL_W'(QUEUE_DEPTH));

   // highest nonempty category wins
   always_comb begin
      pick      = '0;
      any_ready = 1'b0;
      for (int c = 0; c < CATEGORY_COUNT; c++) begin
         if (fill_ff[c] != '0) begin
            pick      = CAT_W'(c);
            any_ready = 1'b1;
         end
      end
   end

   assign mem_wr_en   = adv && is_enq && enq_cat_ok && !enq_full;
   assign mem_wr_addr = ADDR_W'(enq_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_ff[enq_idx]);
   assign mem_wr_data = '{rate: rate_index, handle: s1_handle_ff};
   assign mem_rd_en   = adv && is_deq && any_ready;
   assign mem_rd_addr = ADDR_W'(pick) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_ff[pick]);

   always_comb begin
      for (int c = 0; c < CATEGORY_COUNT; c++) begin
         head_in[c]  = head_ff[c];
         tail_in[c]  = tail_ff[c];
         fill_in[c]  = fill_ff[c];
         qdrop_in[c] = qdrop_ff[c];
      end
      drop_in = drop_ff;
      if (adv && is_enq && enq_cat_ok) begin
         if (enq_full) begin
            qdrop_in[enq_idx] = (qdrop_ff[enq_idx] == COUNT_MAX) ?
                                qdrop_ff[enq_idx] : qdrop_ff[enq_idx] + COUNT_W'(1);
            drop_in = (drop_ff == COUNT_MAX) ? drop_ff : drop_ff + COUNT_W'(1);
         end else begin
            tail_in[enq_idx] = (tail_ff[enq_idx] == PTR_W'(QUEUE_DEPTH - 1)) ?
                               '0 : tail_ff[enq_idx] + PTR_W'(1);
            fill_in[enq_idx] = fill_ff[enq_idx] + FILL_W'(1);
         end
      end
      if (mem_rd_en) begin
         head_in[pick] = (head_ff[pick] == PTR_W'(QUEUE_DEPTH - 1)) ?
                         '0 : head_ff[pick] + PTR_W'(1);
         fill_in[pick] = fill_ff[pick] - FILL_W'(1);
      end
   end

   assign rate_evt.fire = adv && is_out;
   assign rate_evt.ok   = s1_ok_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_status_in = STATUS_OK;
      rsp_cat_in    = '0;
      rsp_hit_in    = 1'b0;
      case (s1_cmd_ff)
         CMD_ENQUEUE: begin
            if (!enq_cat_ok || enq_full) begin
               rsp_status_in = STATUS_FULL;
            end
         end
         CMD_DEQUEUE: begin
            if (any_ready) begin
               rsp_cat_in = 2'(pick);
               rsp_hit_in = 1'b1;
            end else begin
               rsp_status_in = STATUS_EMPTY;
            end
         end
         default: rsp_status_in = STATUS_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_rate     <= MAX_RATE_RESET;
         cfg_ff.up_threshold <= PROBE_RESET;
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         drop_ff             <= '0;
         for (int c = 0; c < CATEGORY_COUNT; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            fill_ff[c]  <= '0;
            qdrop_ff[c] <= '0;
         end
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         drop_ff      <= drop_in;
         for (int c = 0; c < CATEGORY_COUNT; c++) begin
            head_ff[c]  <= head_in[c];
            tail_ff[c]  <= tail_in[c];
            fill_ff[c]  <= fill_in[c];
            qdrop_ff[c] <= qdrop_in[c];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff    <= req_cmd;
         s1_cat_ff    <= req_access_category;
         s1_handle_ff <= req_frame_handle;
         s1_ok_ff     <= req_outcome_ok;
      end
      if (adv) begin
         rsp_status_ff <= rsp_status_in;
         rsp_cat_ff    <= rsp_cat_in;
         rsp_hit_ff    <= rsp_hit_in;
      end
   end

   tpq_store #(
      .DEPTH (MEM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   tpq_rate u_rate (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .evt         (rate_evt),
      .rate_index  (rate_index),
      .retry_total (retry_total)
   );

   // state only moves when an item enters the result stage, so the live
   // counters match the item on display
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_category = rsp_cat_ff;
   assign rsp_out_handle   = rsp_hit_ff ? mem_rd_data.handle : '0;
   assign rsp_out_rate     = rsp_hit_ff ? mem_rd_data.rate : '0;
   assign rsp_current_rate = rate_index;
   assign rsp_drop_total   = drop_ff;
   assign rsp_retry_total  = retry_total;

endmodule
